@@ src/pae_pkg.sv @@
// Shared constants, types and the CORDIC arctangent table for the arc point evaluator.
// No dependencies.
`timescale 1ns / 1ps

package pae_pkg;

    localparam int CORDIC_STAGES = 18;
    localparam int CORDIC_USED   = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    // angle stages + CORDIC stages + product stage + final stage
    localparam int NUM_STAGES    = CORDIC_USED + 4;

    localparam int PARAM_W  = 18;
    localparam int ANGLE_W  = 18;
    localparam int SPAN_W   = 19;
    localparam int COORD_W  = 20;
    localparam int CORD_W   = 34;
    localparam int VEC_W    = 60;

    localparam logic [PARAM_W-1:0] PARAM_ONE = 18'd65536;
    localparam logic [PARAM_W-1:0] PARAM_TWO = 18'd131072;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [26:0] COORD_MAX = 27'sd524287;
    localparam logic signed [26:0] COORD_MIN = -27'sd524288;

    // register indexes on the configuration port
    localparam logic [2:0] REG_CENTER  = 3'd0;
    localparam logic [2:0] REG_COS_AX  = 3'd1;
    localparam logic [2:0] REG_SIN_AX  = 3'd2;
    localparam logic [2:0] REG_FIRST   = 3'd3;
    localparam logic [2:0] REG_END     = 3'd4;
    localparam logic [2:0] REG_REVERSE = 3'd5;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [CORD_W-1:0] z;
        logic [1:0]               quad;
    } pae_cordic_t;

    // arctan(2^-i) in 2^-32 turns
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            24: v = 32'h00000028;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000002;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ src/piecewise_arc_point_evaluator.sv @@
// Top level of the arc point evaluator: APB register file, valid/enable chain, datapath.
// Depends on pae_pkg, pae_angle, pae_cordic, pae_combine.
`timescale 1ns / 1ps
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_curve_param [17:0]
//  m_        out        m_valid / m_ready   m_point_x, m_point_y, m_point_z [19:0] signed
//  APB       in         psel/penable/pwrite paddr [5:0], pwdata/prdata [63:0]
//
//  One item per cycle sustained while m_ready is high. The pipe registers are
//  two angle stages, one per CORDIC iteration, one product stage and the output register.
//  Synchronous active-low reset clears every valid bit and loads register reset values.
//  A stall on m_ready holds only the stages that are full behind it; bubbles close up,
//  so s_ready stays high until the whole pipe is full.

module piecewise_arc_point_evaluator (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [17:0]            s_curve_param,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [19:0]     m_point_x,
    output logic signed [19:0]     m_point_y,
    output logic signed [19:0]     m_point_z,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [5:0]             paddr,
    input  logic [63:0]            pwdata,
    output logic [63:0]            prdata,
    output logic                   pready
);

    localparam int NS = pae_pkg::NUM_STAGES;
    localparam int NC = pae_pkg::CORDIC_USED;

    logic [pae_pkg::VEC_W-1:0]  center_reg;
    logic [pae_pkg::VEC_W-1:0]  cos_axis_reg;
    logic [pae_pkg::VEC_W-1:0]  sin_axis_reg;
    logic [pae_pkg::SPAN_W-1:0] first_span_reg;
    logic [pae_pkg::SPAN_W-1:0] end_angle_reg;
    logic                       reverse_reg;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] en;
    logic          wr_en;
    logic [2:0]    reg_idx;

    logic [pae_pkg::ANGLE_W-1:0] angle;
    pae_pkg::pae_cordic_t        rot;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg     <= '0;
            cos_axis_reg   <= '0;
            sin_axis_reg   <= '0;
            first_span_reg <= 19'd65536;
            end_angle_reg  <= 19'd131072;
            reverse_reg    <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                pae_pkg::REG_CENTER:  center_reg     <= pwdata[59:0];
                pae_pkg::REG_COS_AX:  cos_axis_reg   <= pwdata[59:0];
                pae_pkg::REG_SIN_AX:  sin_axis_reg   <= pwdata[59:0];
                pae_pkg::REG_FIRST:   first_span_reg <= pwdata[18:0];
                pae_pkg::REG_END:     end_angle_reg  <= pwdata[18:0];
                pae_pkg::REG_REVERSE: reverse_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pae_pkg::REG_CENTER:  prdata = {4'h0, center_reg};
            pae_pkg::REG_COS_AX:  prdata = {4'h0, cos_axis_reg};
            pae_pkg::REG_SIN_AX:  prdata = {4'h0, sin_axis_reg};
            pae_pkg::REG_FIRST:   prdata = {45'd0, first_span_reg};
            pae_pkg::REG_END:     prdata = {45'd0, end_angle_reg};
            pae_pkg::REG_REVERSE: prdata = {63'd0, reverse_reg};
            default:              prdata = '0;
        endcase
    end

    // ---------------- valid / enable chain ----------------
    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        en[NS-1] = !valid_reg[NS-1] || m_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = s_valid;
        for (int i = 1; i < NS; i++) begin
            valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = valid_reg[NS-1];

    // ---------------- datapath ----------------
    pae_angle u_angle (
        .aclk          (aclk),
        .en_mul        (en[0]),
        .en_rnd        (en[1]),
        .s_curve_param (s_curve_param),
        .first_span    (first_span_reg),
        .end_angle     (end_angle_reg),
        .reverse_param (reverse_reg),
        .angle_reg     (angle)
    );

    pae_cordic u_cordic (
        .aclk    (aclk),
        .en      (en[NC+1:2]),
        .angle   (angle),
        .rot_out (rot)
    );

    pae_combine u_combine (
        .aclk         (aclk),
        .en_mul       (en[NS-2]),
        .en_out       (en[NS-1]),
        .rot_in       (rot),
        .center_vec   (center_reg),
        .cos_axis_vec (cos_axis_reg),
        .sin_axis_vec (sin_axis_reg),
        .point_x_reg  (m_point_x),
        .point_y_reg  (m_point_y),
        .point_z_reg  (m_point_z)
    );

endmodule

@@ src/pae_angle.sv @@
// Parameter to angle mapping: clamp, reverse, one multiply, round and wrap to a turn.
// Depends on pae_pkg.
`timescale 1ns / 1ps

module pae_angle (
    input  logic                              aclk,
    input  logic                              en_mul,
    input  logic                              en_rnd,
    input  logic [pae_pkg::PARAM_W-1:0]       s_curve_param,
    input  logic [pae_pkg::SPAN_W-1:0]        first_span,
    input  logic [pae_pkg::SPAN_W-1:0]        end_angle,
    input  logic                              reverse_param,
    output logic [pae_pkg::ANGLE_W-1:0]       angle_reg
);

    logic [pae_pkg::PARAM_W-1:0] t_clamp;
    logic [pae_pkg::PARAM_W-1:0] t_eval;
    logic [pae_pkg::PARAM_W-1:0] t_less1;
    logic                        low_half;
    logic signed [19:0]          op_a;
    logic signed [17:0]          op_b;
    logic signed [37:0]          prod_next;
    logic signed [37:0]          prod_reg;
    logic                        low_reg;
    logic signed [37:0]          shifted;
    logic [pae_pkg::ANGLE_W-1:0] angle_next;

    always_comb begin
        t_clamp  = (s_curve_param > pae_pkg::PARAM_TWO) ? pae_pkg::PARAM_TWO : s_curve_param;
        t_eval   = reverse_param ? (pae_pkg::PARAM_TWO - t_clamp) : t_clamp;
        low_half = (t_eval < pae_pkg::PARAM_ONE);
        t_less1  = t_eval - pae_pkg::PARAM_ONE;
        if (low_half) begin
            op_a = $signed({1'b0, first_span});
            op_b = $signed({2'b00, t_eval[15:0]});
        end else begin
            op_a = $signed({1'b0, end_angle}) - $signed({1'b0, first_span});
            op_b = $signed({1'b0, t_less1[16:0]});
        end
        prod_next = 38'(op_a * op_b);
    end

    always_ff @(posedge aclk) begin
        if (en_mul) begin
            prod_reg <= prod_next;
            low_reg  <= low_half;
        end
    end

    // round half up to 2^-18 turns, then wrap to one turn
    always_comb begin
        shifted    = (prod_reg + 38'sd32768) >>> 16;
        angle_next = shifted[17:0] + (low_reg ? 18'd0 : first_span[17:0]);
    end

    always_ff @(posedge aclk) begin
        if (en_rnd) begin
            angle_reg <= angle_next;
        end
    end

endmodule

@@ src/pae_cordic.sv @@
// Rotation-mode CORDIC, one register stage per iteration, with quadrant split at entry.
// Depends on pae_pkg.
`timescale 1ns / 1ps

module pae_cordic (
    input  logic                                aclk,
    input  logic [pae_pkg::CORDIC_USED-1:0]     en,
    input  logic [pae_pkg::ANGLE_W-1:0]         angle,
    output pae_pkg::pae_cordic_t                rot_out
);

    pae_pkg::pae_cordic_t         stage_in [pae_pkg::CORDIC_USED];
    pae_pkg::pae_cordic_t         stage_reg [pae_pkg::CORDIC_USED];
    logic [pae_pkg::ANGLE_W-1:0]  angle_bias;
    logic [pae_pkg::ANGLE_W-1:0]  resid;

    // split off nearest quadrant; remainder lies in [-1/8, 1/8) turn
    always_comb begin
        angle_bias        = angle + 18'h08000;
        resid             = angle - {angle_bias[17:16], 16'h0000};
        stage_in[0].x     = pae_pkg::CORDIC_GAIN;
        stage_in[0].y     = '0;
        stage_in[0].z     = $signed({{3{resid[16]}}, resid[16:0], 14'h0000});
        stage_in[0].quad  = angle_bias[17:16];
    end

    for (genvar k = 0; k < pae_pkg::CORDIC_USED; k++) begin : g_stage
        pae_pkg::pae_cordic_t       nxt;
        logic signed [pae_pkg::CORD_W-1:0] dx;
        logic signed [pae_pkg::CORD_W-1:0] dy;
        logic signed [pae_pkg::CORD_W-1:0] at;

        always_comb begin
            dx       = stage_in[k].y >>> k;
            dy       = stage_in[k].x >>> k;
            at       = $signed({2'b00, pae_pkg::atan_turn(k)});
            nxt.quad = stage_in[k].quad;
            if (!stage_in[k].z[pae_pkg::CORD_W-1]) begin
                nxt.x = stage_in[k].x - dx;
                nxt.y = stage_in[k].y + dy;
                nxt.z = stage_in[k].z - at;
            end else begin
                nxt.x = stage_in[k].x + dx;
                nxt.y = stage_in[k].y - dy;
                nxt.z = stage_in[k].z + at;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                stage_reg[k] <= nxt;
            end
        end

        if (k + 1 < pae_pkg::CORDIC_USED) begin : g_link
            assign stage_in[k+1] = stage_reg[k];
        end
    end

    assign rot_out = stage_reg[pae_pkg::CORDIC_USED-1];

endmodule

@@ src/pae_combine.sv @@
// Quadrant fix-up, axis products, rounding, centre offset and saturation.
// Depends on pae_pkg.
`timescale 1ns / 1ps

module pae_combine (
    input  logic                                 aclk,
    input  logic                                 en_mul,
    input  logic                                 en_out,
    input  pae_pkg::pae_cordic_t                 rot_in,
    input  logic [pae_pkg::VEC_W-1:0]            center_vec,
    input  logic [pae_pkg::VEC_W-1:0]            cos_axis_vec,
    input  logic [pae_pkg::VEC_W-1:0]            sin_axis_vec,
    output logic signed [pae_pkg::COORD_W-1:0]   point_x_reg,
    output logic signed [pae_pkg::COORD_W-1:0]   point_y_reg,
    output logic signed [pae_pkg::COORD_W-1:0]   point_z_reg
);

    logic signed [pae_pkg::CORD_W-1:0] cos_v;
    logic signed [pae_pkg::CORD_W-1:0] sin_v;
    logic signed [53:0] pc_reg [3];
    logic signed [53:0] ps_reg [3];
    logic signed [pae_pkg::COORD_W-1:0] coord_next [3];

    always_comb begin
        case (rot_in.quad)
            2'd1: begin
                cos_v = -rot_in.y;
                sin_v = rot_in.x;
            end
            2'd2: begin
                cos_v = -rot_in.x;
                sin_v = -rot_in.y;
            end
            2'd3: begin
                cos_v = rot_in.y;
                sin_v = -rot_in.x;
            end
            default: begin
                cos_v = rot_in.x;
                sin_v = rot_in.y;
            end
        endcase
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [19:0] ca;
        logic signed [19:0] sa;
        logic signed [19:0] ce;
        logic signed [54:0] sum;
        logic signed [54:0] rnd;
        logic signed [26:0] val;

        assign ca = $signed(cos_axis_vec[20*k +: 20]);
        assign sa = $signed(sin_axis_vec[20*k +: 20]);
        assign ce = $signed(center_vec[20*k +: 20]);

        always_ff @(posedge aclk) begin
            if (en_mul) begin
                pc_reg[k] <= 54'(ca * cos_v);
                ps_reg[k] <= 54'(sa * sin_v);
            end
        end

        // round half up from Q.42 to Q8.12, add centre, clamp
        always_comb begin
            sum = 55'(pc_reg[k]) + 55'(ps_reg[k]);
            rnd = (sum + 55'sd536870912) >>> 30;
            val = 27'(rnd) + 27'(ce);
            if (val > pae_pkg::COORD_MAX) begin
                coord_next[k] = pae_pkg::COORD_MAX[19:0];
            end else if (val < pae_pkg::COORD_MIN) begin
                coord_next[k] = pae_pkg::COORD_MIN[19:0];
            end else begin
                coord_next[k] = val[19:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            point_x_reg <= coord_next[0];
            point_y_reg <= coord_next[1];
            point_z_reg <= coord_next[2];
        end
    end

endmodule

@@ src/pae_checker.sv @@
// Port-level checks for the arc point evaluator, bound to the top level.
// Depends on piecewise_arc_point_evaluator.
`timescale 1ns / 1ps

module pae_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [19:0] m_point_x,
    input logic signed [19:0] m_point_y,
    input logic signed [19:0] m_point_z,
    input logic               pready
);

    // an empty output means the whole pipe can move
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // reset drains the pipe
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_x)
            && $stable(m_point_y) && $stable(m_point_z))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind piecewise_arc_point_evaluator pae_checker u_pae_checker (.*);

@@ bench/piecewise_arc_point_evaluator_test.sv @@
// Self-checking bench for piecewise_arc_point_evaluator: predicts every arc point in
// SystemVerilog and compares it, field by field, with the result channel.
// Depends on pae_pkg and the piecewise_arc_point_evaluator RTL.
`timescale 1ns / 1ps

module piecewise_arc_point_evaluator_test;

    localparam int WATCHDOG_LIMIT = 4000;
    // used for draining the pipe before register writes
    localparam int DRAIN_CYCLES   = pae_pkg::NUM_STAGES + 10;
    localparam logic [59:0] VEC_MASK  = 60'hFFF_FFFF_FFFF_FFFF;
    localparam longint      TURN_MASK = 64'h3FFFF;

    typedef struct packed {
        logic signed [pae_pkg::COORD_W-1:0] x;
        logic signed [pae_pkg::COORD_W-1:0] y;
        logic signed [pae_pkg::COORD_W-1:0] z;
    } arc_point_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [pae_pkg::PARAM_W-1:0]        s_curve_param;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [pae_pkg::COORD_W-1:0] m_point_x;
    logic signed [pae_pkg::COORD_W-1:0] m_point_y;
    logic signed [pae_pkg::COORD_W-1:0] m_point_z;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [5:0]                         paddr;
    logic [63:0]                        pwdata;
    logic [63:0]                        prdata;
    logic                               pready;

    // shadow copy of the register file, updated as each write lands
    logic [59:0]                arc_center;
    logic [59:0]                arc_cos_axis;
    logic [59:0]                arc_sin_axis;
    logic [pae_pkg::SPAN_W-1:0] arc_first_span;
    logic [pae_pkg::SPAN_W-1:0] arc_end_angle;
    logic                       arc_reverse;

    arc_point_t pending_points[$];
    int         mismatch_count;
    int         idle_cycles;
    bit         sink_hold;      // receiver holds off while set
    bit         quiet_phase;    // no random gaps or new random stalls while set
    int         sink_stall_left;

    // arctan(2^-i) in 2^-32 turns
    longint atan_step[32] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001,
        64'h0, 64'h0
    };

    piecewise_arc_point_evaluator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_curve_param (s_curve_param),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_point_z     (m_point_z),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 aclk = ~aclk;

    // Sign-extend one 20-bit lane of a packed vector.
    function automatic longint vec_lane(input logic [59:0] v, input int k);
        logic signed [pae_pkg::COORD_W-1:0] raw;
        raw = v[20*k +: 20];
        return longint'(raw);
    endfunction

    // Map the curve parameter to an angle in 2^-18 turns, two linear pieces.
    function automatic longint arc_angle(input logic [pae_pkg::PARAM_W-1:0] param);
        longint t;
        longint prod;
        t = longint'(param);
        if (t > longint'(pae_pkg::PARAM_TWO)) t = longint'(pae_pkg::PARAM_TWO);
        if (arc_reverse) t = longint'(pae_pkg::PARAM_TWO) - t;
        if (t < longint'(pae_pkg::PARAM_ONE)) begin
            prod = longint'(arc_first_span) * t + 32768;
            return (prod >>> 16) & TURN_MASK;
        end
        prod = (longint'(arc_end_angle) - longint'(arc_first_span)) *
               (t - longint'(pae_pkg::PARAM_ONE));
        return (longint'(arc_first_span) + ((prod + 32768) >>> 16)) & TURN_MASK;
    endfunction

    // Quadrant split, then rotation-mode CORDIC on the remainder; returns Q1.30 cos/sin.
    task automatic arc_sincos(input longint angle, output longint cos_v, output longint sin_v);
        longint quad;
        longint rem;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint tmp;
        quad = ((angle + 64'h8000) >> 16) & 3;
        rem  = angle - quad * 65536;
        if (rem >= 131072) rem -= 262144;
        x = longint'(pae_pkg::CORDIC_GAIN);
        y = 0;
        z = rem * 16384;
        for (int i = 0; i < pae_pkg::CORDIC_USED; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step[i];
            end else begin
                x += dx; y -= dy; z += atan_step[i];
            end
        end
        case (quad)
            1: begin tmp = x; x = -y; y = tmp; end
            2: begin x = -x; y = -y; end
            3: begin tmp = x; x = y; y = -tmp; end
            default: ;
        endcase
        cos_v = x;
        sin_v = y;
    endtask

    // Expected point for one curve parameter under the current register settings.
    task automatic predict_arc_point(input logic [pae_pkg::PARAM_W-1:0] param,
                                     output arc_point_t pt);
        longint cos_v;
        longint sin_v;
        longint coord[3];
        arc_sincos(arc_angle(param), cos_v, sin_v);
        for (int k = 0; k < 3; k++) begin
            coord[k] = ((vec_lane(arc_cos_axis, k) * cos_v + vec_lane(arc_sin_axis, k) * sin_v
                        + (64'sd1 <<< 29)) >>> 30) + vec_lane(arc_center, k);
            if (coord[k] > 524287) coord[k] = 524287;
            if (coord[k] < -524288) coord[k] = -524288;
        end
        pt.x = coord[0][pae_pkg::COORD_W-1:0];
        pt.y = coord[1][pae_pkg::COORD_W-1:0];
        pt.z = coord[2][pae_pkg::COORD_W-1:0];
    endtask

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offer one item; called at a falling edge, returns at a falling edge.
    task automatic send_param(input logic [pae_pkg::PARAM_W-1:0] param);
        int gap;
        arc_point_t pt;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_curve_param <= param;
        do @(posedge aclk); while (!s_ready);
        predict_arc_point(param, pt);
        pending_points = {pending_points, pt};
        @(negedge aclk);
    endtask

    // Lower valid and wait for every expected point, then for the pipe to settle.
    task automatic drain_pipe();
        s_valid <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // APB write: setup cycle, access cycle; the shadow register follows at the access edge.
    task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (index)
            pae_pkg::REG_CENTER:  arc_center     = value[59:0];
            pae_pkg::REG_COS_AX:  arc_cos_axis   = value[59:0];
            pae_pkg::REG_SIN_AX:  arc_sin_axis   = value[59:0];
            pae_pkg::REG_FIRST:   arc_first_span = value[pae_pkg::SPAN_W-1:0];
            pae_pkg::REG_END:     arc_end_angle  = value[pae_pkg::SPAN_W-1:0];
            pae_pkg::REG_REVERSE: arc_reverse    = value[0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_arc(input logic [59:0] center, input logic [59:0] cos_axis,
                           input logic [59:0] sin_axis,
                           input logic [pae_pkg::SPAN_W-1:0] first_span,
                           input logic [pae_pkg::SPAN_W-1:0] end_angle, input logic reverse);
        write_reg(pae_pkg::REG_CENTER,  {4'h0, center});
        write_reg(pae_pkg::REG_COS_AX,  {4'h0, cos_axis});
        write_reg(pae_pkg::REG_SIN_AX,  {4'h0, sin_axis});
        write_reg(pae_pkg::REG_FIRST,   {45'd0, first_span});
        write_reg(pae_pkg::REG_END,     {45'd0, end_angle});
        write_reg(pae_pkg::REG_REVERSE, {63'd0, reverse});
    endtask

    function automatic logic [59:0] rand_vec();
        return 60'({$urandom, $urandom}) & VEC_MASK;
    endfunction

    // Moderate lanes within +-8.0 so most points stay clear of saturation.
    function automatic logic [59:0] rand_small_vec();
        logic [59:0] v;
        for (int k = 0; k < 3; k++) v[20*k +: 20] = 20'($signed($urandom_range(0, 65535)) - 32768);
        return v;
    endfunction

    // Mostly within [0, 2], some beyond two so every parameter bit toggles.
    function automatic logic [pae_pkg::PARAM_W-1:0] rand_param();
        if ($urandom_range(0, 9) == 0) return pae_pkg::PARAM_W'($urandom);
        return pae_pkg::PARAM_W'($urandom_range(0, 131072));
    endfunction

    // Reset settings give zero points; then the parameter corners, reverse,
    // span extremes, spans past a full turn and saturated coordinates.
    task automatic test_directed();
        logic [pae_pkg::PARAM_W-1:0] corners[10] = '{18'd0, 18'd1, 18'd32768, 18'd65535,
                                                     18'd65536, 18'd65537, 18'd98304,
                                                     18'd131071, 18'd131072, 18'h3FFFF};
        send_param(18'd0);
        send_param(pae_pkg::PARAM_ONE);
        drain_pipe();
        set_arc(rand_small_vec(), rand_small_vec(), rand_small_vec(),
                19'd65536, 19'd131072, 1'b0);
        foreach (corners[i]) send_param(corners[i]);
        drain_pipe();
        write_reg(pae_pkg::REG_REVERSE, 64'd1);
        send_param(18'd0);
        send_param(18'd65536);
        send_param(18'd131073);
        drain_pipe();
        set_arc(rand_small_vec(), rand_small_vec(), rand_small_vec(), 19'd0, 19'd262144, 1'b0);
        send_param(18'd65535);
        send_param(18'd131072);
        drain_pipe();
        set_arc(rand_small_vec(), rand_small_vec(), rand_small_vec(), 19'h7FFFF, 19'd0, 1'b1);
        send_param(18'd12345);
        send_param(18'd100000);
        drain_pipe();
        // full-scale lanes drive the first point to the upper clamp here, the second to the lower clamp below
        set_arc({3{20'h7FFFF}}, {3{20'h7FFFF}}, {3{20'h7FFFF}}, 19'd65536, 19'd131072, 1'b0);
        send_param(18'd0);
        send_param(18'd131072);
        drain_pipe();
        set_arc({3{20'h80000}}, {3{20'h7FFFF}}, {3{20'h80000}}, 19'd65536, 19'd131072, 1'b0);
        send_param(18'd0);
        send_param(18'd65536);
        drain_pipe();
    endtask

    // Several register settings, extremes among them, each followed by random items.
    task automatic test_random_phases();
        logic [pae_pkg::SPAN_W-1:0] first_span;
        logic [pae_pkg::SPAN_W-1:0] end_angle;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin first_span = 19'd0;      end_angle = 19'd0;      end
                1: begin first_span = 19'd262144; end_angle = 19'd262144; end
                2: begin first_span = 19'h7FFFF;  end_angle = 19'h7FFFF;  end
                3: begin first_span = 19'd65536;  end_angle = 19'd131072; end
                default: begin
                    first_span = pae_pkg::SPAN_W'($urandom);
                    end_angle  = pae_pkg::SPAN_W'($urandom_range(0, 262144));
                end
            endcase
            if (phase % 3 == 2)
                set_arc(rand_vec(), rand_vec(), rand_vec(), first_span, end_angle, phase[0]);
            else
                set_arc(rand_small_vec(), rand_small_vec(), rand_small_vec(),
                        first_span, end_angle, phase[0]);
            quiet_phase = (phase == 5);
            repeat (220) send_param(rand_param());
            quiet_phase = 1'b0;
            drain_pipe();
        end
    endtask

    // Hold the receiver off while items keep coming, so the pipe fills and s_ready drops.
    task automatic test_backpressure();
        set_arc(rand_small_vec(), rand_small_vec(), rand_small_vec(),
                pae_pkg::SPAN_W'($urandom_range(0, 262144)),
                pae_pkg::SPAN_W'($urandom_range(0, 262144)), 1'b0);
        quiet_phase = 1'b1;
        fork
            begin
                sink_hold = 1'b1;
                repeat (300) @(posedge aclk);
                sink_hold = 1'b0;
            end
            repeat (80) send_param(rand_param());
        join
        quiet_phase = 1'b0;
        drain_pipe();
    endtask

    // Receiver: random stalls, mostly short, with long holds when asked.
    always @(negedge aclk) begin
        if (!aresetn || sink_hold) begin
            m_ready <= 1'b0;
        end else if (sink_stall_left > 0) begin
            m_ready <= 1'b0;
            sink_stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!quiet_phase && $urandom_range(0, 7) == 0)
                sink_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                              : $urandom_range(1, 3);
        end
    end

    // Compare each accepted point with the oldest expectation.
    always @(posedge aclk) begin
        arc_point_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("unexpected point (%0d, %0d, %0d)",
                                          m_point_x, m_point_y, m_point_z));
            end else begin
                want = pending_points.pop_front();
                if (m_point_x !== want.x)
                    report_mismatch($sformatf("point_x: got %0d, expected %0d",
                                              m_point_x, want.x));
                if (m_point_y !== want.y)
                    report_mismatch($sformatf("point_y: got %0d, expected %0d",
                                              m_point_y, want.y));
                if (m_point_z !== want.z)
                    report_mismatch($sformatf("point_z: got %0d, expected %0d",
                                              m_point_z, want.z));
            end
        end
    end

    // Watchdog: count cycles with no item moving on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog expired", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        aclk            = 1'b0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_curve_param   = '0;
        m_ready         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        mismatch_count  = 0;
        idle_cycles     = 0;
        sink_hold       = 1'b0;
        quiet_phase     = 1'b0;
        sink_stall_left = 0;
        // register reset values
        arc_center      = '0;
        arc_cos_axis    = '0;
        arc_sin_axis    = '0;
        arc_first_span  = 19'd65536;
        arc_end_angle   = 19'd131072;
        arc_reverse     = 1'b0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_phases();
        test_backpressure();

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
